[hw/rtl/l1bp_pkg.sv]
`timescale 1ns / 1ps

package l1bp_pkg;

  localparam int SAMPLE_BITS     = 32;
  localparam int RADIUS_BITS     = 31;
  localparam int VALUE_BITS      = 32;
  localparam int INDEX_BITS      = 6;
  localparam int MAX_LEN_DEFAULT = 64;

  // Threshold width: wide enough for a magnitude minus the radius and the
  // differences taken against it.
  localparam int TAU_BITS =
    ((SAMPLE_BITS > RADIUS_BITS) ? SAMPLE_BITS : RADIUS_BITS) + 3;

  localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = RADIUS_BITS'(65536);

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last_sample;
  } sample_item_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] projected_value;
    logic [INDEX_BITS-1:0]        element_index;
    logic                         last_result;
    logic                         truncated;
  } result_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_LDIV,
    ST_FLUSH,
    ST_PV_INIT,
    ST_PV_RD,
    ST_PV_CHK,
    ST_PV_DIV,
    ST_FI_INIT,
    ST_FI_RD,
    ST_FI_CHK,
    ST_FI_DIV,
    ST_EMIT_INIT,
    ST_EMIT_RD,
    ST_EMIT_WAIT,
    ST_EMIT_OUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic load_step;
    logic load_finish;
    logic pv_init;
    logic pv_read;
    logic pv_check;
    logic fi_init;
    logic fi_check;
    logic tau_add;
    logic emit_init;
    logic emit_load;
    logic emit_next;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic load_divides;
    logic last;
    logic refine_needed;
    logic pv_done;
    logic c_gt_tau;
    logic fi_end;
    logic fi_repeat;
    logic fi_div_zero;
    logic emit_last;
    logic sc_zero;
    logic div_done;
  } status_t;

endpackage

[hw/rtl/l1_ball_projection_online_pivot.sv]
`timescale 1ns / 1ps
// Channel   Direction  Handshake                     Payload
// sample    in         sample_valid / sample_ready   sample_item (l1bp_pkg::sample_item_t)
// result    out        result_valid / result_ready   result_item (l1bp_pkg::result_item_t)
// radius    in         radius_we (no wait)           radius_wdata
//
// A sample is taken in ST_IDLE and stored in ST_LOAD; when it needs a division
// to update the threshold, the iterative divider runs in ST_LDIV first.
// After the marked sample, refinement visits the candidates and then runs
// filtering passes, with a division for each threshold update; then results
// leave one at a time, each read, registered and held until result_ready is high.
// Reset is synchronous; stores need no clearing pass. A stalled result holds
// the block until the transaction completes.

module l1_ball_projection_online_pivot #(
  parameter int MAX_LEN = l1bp_pkg::MAX_LEN_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             sample_valid,
  output logic                             sample_ready,
  input  l1bp_pkg::sample_item_t           sample_item,
  output logic                             result_valid,
  input  logic                             result_ready,
  output l1bp_pkg::result_item_t           result_item,
  input  logic                             radius_we,
  input  logic [l1bp_pkg::RADIUS_BITS-1:0] radius_wdata
);

  l1bp_pkg::cmd_t    cmd;
  l1bp_pkg::status_t status;
  l1bp_pkg::state_t  state;

  l1bp_control u_control (
    .clk         (clk),
    .rst         (rst),
    .sample_valid(sample_valid),
    .sample_ready(sample_ready),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .status      (status),
    .cmd         (cmd),
    .state       (state)
  );

  l1bp_datapath #(
    .MAX_LEN(MAX_LEN)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .sample_item (sample_item),
    .radius_we   (radius_we),
    .radius_wdata(radius_wdata),
    .result_item (result_item)
  );

`ifndef NO_ASSERTIONS
  // Loading and emitting never overlap.
  assert property (@(posedge clk) disable iff (rst) !(result_valid && sample_ready))
    else $error("result offered while a sample can be taken");

  // An accepted sample closes the input until its load has been done.
  assert property (@(posedge clk) disable iff (rst)
    (sample_valid && sample_ready) |=> !sample_ready)
    else $error("input stayed open after a sample transaction");

  // The final result of a vector returns the block to idle.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_ready && result_item.last_result) |=>
      (!result_valid && state == l1bp_pkg::ST_IDLE))
    else $error("block did not return to idle after the final result");
`endif

endmodule

[hw/rtl/l1bp_ram.sv]
`timescale 1ns / 1ps

module l1bp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/l1bp_divider.sv]
`timescale 1ns / 1ps

module l1bp_divider #(
  parameter int DW = 35,
  parameter int VW = 7
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [DW-1:0] dividend,
  input  logic [VW-1:0]        divisor,
  output logic                 done,
  output logic signed [DW-1:0] quotient
);

  localparam int NW = $clog2(DW + 1);

  logic          busy;
  logic [NW-1:0] count;
  logic [DW-1:0] q;
  logic [VW-1:0] rem;
  logic [VW-1:0] dvs;
  logic          neg;
  logic [VW:0]   rem_sh;
  logic [VW:0]   diff;
  logic          ge;

  // Restoring division on magnitudes, one quotient bit a cycle; the sign is
  // applied at the end so that the result truncates towards zero.
  assign rem_sh   = {rem, q[DW-1]};
  assign diff     = rem_sh - {1'b0, dvs};
  assign ge       = !diff[VW];
  assign quotient = neg ? $signed(-q) : $signed(q);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= NW'(DW);
      end else if (busy) begin
        count <= count - NW'(1);
        if (count == NW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend[DW-1] ? (DW'(0) - DW'(dividend)) : DW'(dividend);
      rem <= '0;
      dvs <= divisor;
      neg <= dividend[DW-1];
    end else if (busy) begin
      rem <= ge ? diff[VW-1:0] : rem_sh[VW-1:0];
      q   <= {q[DW-2:0], ge};
    end
  end

endmodule

[hw/rtl/l1bp_datapath.sv]
`timescale 1ns / 1ps

module l1bp_datapath #(
  parameter int MAX_LEN = l1bp_pkg::MAX_LEN_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  l1bp_pkg::cmd_t                      cmd,
  output l1bp_pkg::status_t                   status,
  input  l1bp_pkg::sample_item_t              sample_item,
  input  logic                                radius_we,
  input  logic [l1bp_pkg::RADIUS_BITS-1:0]    radius_wdata,
  output l1bp_pkg::result_item_t              result_item
);

  localparam int SB = l1bp_pkg::SAMPLE_BITS;
  localparam int RW = l1bp_pkg::RADIUS_BITS;
  localparam int TW = l1bp_pkg::TAU_BITS;
  localparam int VB = l1bp_pkg::VALUE_BITS;
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CW = $clog2(MAX_LEN + 1);

  logic signed [SB-1:0] y;
  logic                 last;
  logic [RW-1:0]        radius;
  logic [CW-1:0]        sc;
  logic [CW-1:0]        cc;
  logic [CW-1:0]        p1;
  logic [CW-1:0]        base;
  logic [CW-1:0]        len;
  logic [CW-1:0]        rp;
  logic [CW-1:0]        ri;
  logic [CW-1:0]        prev;
  logic [CW-1:0]        oi;
  logic signed [TW-1:0] tau;
  logic                 ovf;

  logic [SB-1:0]        y_u;
  logic [SB-1:0]        mag;
  logic signed [TW-1:0] mag_ext;
  logic signed [TW-1:0] a_ext;
  logic signed [TW-1:0] c_ext;
  logic signed [TW-1:0] mag_minus_a;
  logic signed [TW-1:0] tau_new;
  logic                 ovf_now;
  logic                 load_divides;
  logic                 c_gt_tau;
  logic [CW-1:0]        fi_div;
  logic                 pass;

  logic                 div_start;
  logic signed [TW-1:0] div_dividend;
  logic [CW-1:0]        div_divisor;
  logic                 div_done;
  logic signed [TW-1:0] div_quotient;

  logic                 cand_we;
  logic [AW-1:0]        cand_waddr;
  logic [SB-1:0]        cand_wdata;
  logic [AW-1:0]        cand_raddr;
  logic [SB-1:0]        cand_rdata;
  logic                 samp_we;
  logic [SB-1:0]        samp_rdata;

  logic signed [TW-1:0] ye;
  logic signed [TW-1:0] y_minus;
  logic signed [TW-1:0] y_plus;
  logic signed [TW-1:0] x;

  assign y_u         = y;
  assign mag         = y[SB-1] ? (SB'(0) - y_u) : y_u;
  assign mag_ext     = $signed({{(TW-SB){1'b0}}, mag});
  assign a_ext       = $signed({{(TW-RW){1'b0}}, radius});
  assign c_ext       = $signed({{(TW-SB){1'b0}}, cand_rdata});
  assign mag_minus_a = mag_ext - a_ext;
  assign tau_new     = tau + div_quotient;
  assign ovf_now     = (sc >= CW'(MAX_LEN));
  assign load_divides = !ovf_now && (sc != '0) && (y != '0) && (mag_ext > tau);
  assign c_gt_tau    = c_ext > tau;
  assign fi_div      = prev - ri - CW'(1) + len;
  assign pass        = (tau <= $signed(TW'(0)));

  always_comb begin
    if (cmd.load_step) begin
      div_dividend = mag_ext - tau;
      div_divisor  = cc - p1 + CW'(1);
    end else if (cmd.pv_check) begin
      div_dividend = c_ext - tau;
      div_divisor  = len + CW'(1);
    end else begin
      div_dividend = tau - c_ext;
      div_divisor  = fi_div;
    end
  end

  assign div_start = (cmd.load_step && load_divides) ||
                     (cmd.pv_check && c_gt_tau) ||
                     (cmd.fi_check && !c_gt_tau && (fi_div != '0));

  l1bp_divider #(
    .DW(TW),
    .VW(CW)
  ) u_divider (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor (div_divisor),
    .done    (div_done),
    .quotient(div_quotient)
  );

  // The candidate list is filtered in place during refinement: writes only
  // ever land on entries that have already been read.
  assign cand_we = (cmd.load_step && !ovf_now && ((sc == '0) || load_divides)) ||
                   ((cmd.pv_check || cmd.fi_check) && c_gt_tau);

  always_comb begin
    if (cmd.load_step) begin
      cand_waddr = cc[AW-1:0];
      cand_wdata = mag;
    end else if (cmd.pv_check) begin
      cand_waddr = AW'(base - CW'(1));
      cand_wdata = cand_rdata;
    end else begin
      cand_waddr = AW'(base + len);
      cand_wdata = cand_rdata;
    end
    if (cmd.pv_read) begin
      cand_raddr = AW'(rp - CW'(1));
    end else begin
      cand_raddr = AW'(base + ri);
    end
  end

  l1bp_ram #(
    .WIDTH(SB),
    .DEPTH(MAX_LEN)
  ) u_cand_ram (
    .clk  (clk),
    .we   (cand_we),
    .waddr(cand_waddr),
    .wdata(cand_wdata),
    .raddr(cand_raddr),
    .rdata(cand_rdata)
  );

  assign samp_we = cmd.load_step && !ovf_now;

  l1bp_ram #(
    .WIDTH(SB),
    .DEPTH(MAX_LEN)
  ) u_samp_ram (
    .clk  (clk),
    .we   (samp_we),
    .waddr(sc[AW-1:0]),
    .wdata(y_u),
    .raddr(oi[AW-1:0]),
    .rdata(samp_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      y    <= sample_item.sample;
      last <= sample_item.last_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= l1bp_pkg::RADIUS_RESET;
      sc     <= '0;
      cc     <= '0;
      p1     <= '0;
      tau    <= '0;
      ovf    <= 1'b0;
      base   <= '0;
      len    <= '0;
      rp     <= '0;
      ri     <= '0;
      prev   <= '0;
      oi     <= '0;
    end else begin
      if (radius_we) begin
        radius <= radius_wdata;
      end
      if (cmd.load_step) begin
        if (ovf_now) begin
          ovf <= 1'b1;
        end else begin
          sc <= sc + CW'(1);
          if (sc == '0) begin
            cc  <= CW'(1);
            p1  <= '0;
            tau <= mag_minus_a;
          end
        end
      end
      if (cmd.load_finish) begin
        cc <= cc + CW'(1);
        if (tau_new <= mag_minus_a) begin
          tau <= mag_minus_a;
          p1  <= cc;
        end else begin
          tau <= tau_new;
        end
      end
      if (cmd.tau_add) begin
        tau <= tau_new;
      end
      if (cmd.pv_init) begin
        base <= p1;
        len  <= cc - p1;
        rp   <= p1;
      end
      if (cmd.pv_read) begin
        rp <= rp - CW'(1);
      end
      if (cmd.pv_check && c_gt_tau) begin
        base <= base - CW'(1);
        len  <= len + CW'(1);
      end
      if (cmd.fi_init) begin
        prev <= len;
        len  <= '0;
        ri   <= '0;
      end
      if (cmd.fi_check) begin
        ri <= ri + CW'(1);
        if (c_gt_tau) begin
          len <= len + CW'(1);
        end
      end
      if (cmd.emit_init) begin
        oi <= '0;
      end
      if (cmd.emit_next) begin
        oi <= oi + CW'(1);
      end
      if (cmd.clear) begin
        sc  <= '0;
        cc  <= '0;
        p1  <= '0;
        tau <= '0;
        ovf <= 1'b0;
      end
    end
  end

  assign ye      = TW'($signed(samp_rdata));
  assign y_minus = ye - tau;
  assign y_plus  = ye + tau;

  always_comb begin
    if (radius == '0) begin
      x = '0;
    end else if (pass) begin
      x = ye;
    end else if (y_minus > $signed(TW'(0))) begin
      x = y_minus;
    end else if (y_plus < $signed(TW'(0))) begin
      x = y_plus;
    end else begin
      x = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      result_item.projected_value <= x[VB-1:0];
      result_item.element_index   <= l1bp_pkg::INDEX_BITS'(oi);
      result_item.last_result     <= status.emit_last;
      result_item.truncated       <= ovf;
    end
  end

  always_comb begin
    status.load_divides  = load_divides;
    status.last          = last;
    status.refine_needed = !pass && (radius != '0);
    status.pv_done       = (rp == '0);
    status.c_gt_tau      = c_gt_tau;
    status.fi_end        = (ri == prev);
    status.fi_repeat     = (len != prev);
    status.fi_div_zero   = (fi_div == '0);
    status.emit_last     = ((oi + CW'(1)) == sc);
    status.sc_zero       = (sc == '0);
    status.div_done      = div_done;
  end

endmodule

[hw/rtl/l1bp_control.sv]
`timescale 1ns / 1ps

module l1bp_control (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_ready,
  output logic               result_valid,
  input  logic               result_ready,
  input  l1bp_pkg::status_t  status,
  output l1bp_pkg::cmd_t     cmd,
  output l1bp_pkg::state_t   state
);

  l1bp_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= l1bp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      l1bp_pkg::ST_IDLE: begin
        if (sample_valid) begin
          state_next = l1bp_pkg::ST_LOAD;
        end
      end
      l1bp_pkg::ST_LOAD: begin
        if (status.load_divides) begin
          state_next = l1bp_pkg::ST_LDIV;
        end else if (status.last) begin
          state_next = l1bp_pkg::ST_FLUSH;
        end else begin
          state_next = l1bp_pkg::ST_IDLE;
        end
      end
      l1bp_pkg::ST_LDIV: begin
        if (status.div_done) begin
          state_next = status.last ? l1bp_pkg::ST_FLUSH : l1bp_pkg::ST_IDLE;
        end
      end
      l1bp_pkg::ST_FLUSH: begin
        state_next = status.refine_needed ? l1bp_pkg::ST_PV_INIT
                                          : l1bp_pkg::ST_EMIT_INIT;
      end
      l1bp_pkg::ST_PV_INIT: begin
        state_next = l1bp_pkg::ST_PV_RD;
      end
      l1bp_pkg::ST_PV_RD: begin
        state_next = status.pv_done ? l1bp_pkg::ST_FI_INIT : l1bp_pkg::ST_PV_CHK;
      end
      l1bp_pkg::ST_PV_CHK: begin
        state_next = status.c_gt_tau ? l1bp_pkg::ST_PV_DIV : l1bp_pkg::ST_PV_RD;
      end
      l1bp_pkg::ST_PV_DIV: begin
        if (status.div_done) begin
          state_next = l1bp_pkg::ST_PV_RD;
        end
      end
      l1bp_pkg::ST_FI_INIT: begin
        state_next = l1bp_pkg::ST_FI_RD;
      end
      l1bp_pkg::ST_FI_RD: begin
        if (!status.fi_end) begin
          state_next = l1bp_pkg::ST_FI_CHK;
        end else if (status.fi_repeat) begin
          state_next = l1bp_pkg::ST_FI_INIT;
        end else begin
          state_next = l1bp_pkg::ST_EMIT_INIT;
        end
      end
      l1bp_pkg::ST_FI_CHK: begin
        if (status.c_gt_tau || status.fi_div_zero) begin
          state_next = l1bp_pkg::ST_FI_RD;
        end else begin
          state_next = l1bp_pkg::ST_FI_DIV;
        end
      end
      l1bp_pkg::ST_FI_DIV: begin
        if (status.div_done) begin
          state_next = l1bp_pkg::ST_FI_RD;
        end
      end
      l1bp_pkg::ST_EMIT_INIT: begin
        state_next = status.sc_zero ? l1bp_pkg::ST_IDLE : l1bp_pkg::ST_EMIT_RD;
      end
      l1bp_pkg::ST_EMIT_RD: begin
        state_next = l1bp_pkg::ST_EMIT_WAIT;
      end
      l1bp_pkg::ST_EMIT_WAIT: begin
        state_next = l1bp_pkg::ST_EMIT_OUT;
      end
      l1bp_pkg::ST_EMIT_OUT: begin
        if (result_ready) begin
          state_next = status.emit_last ? l1bp_pkg::ST_IDLE : l1bp_pkg::ST_EMIT_RD;
        end
      end
      default: begin
        state_next = l1bp_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd          = '0;
    sample_ready = 1'b0;
    result_valid = 1'b0;
    case (state)
      l1bp_pkg::ST_IDLE: begin
        sample_ready = 1'b1;
        cmd.accept   = sample_valid;
      end
      l1bp_pkg::ST_LOAD: begin
        cmd.load_step = 1'b1;
      end
      l1bp_pkg::ST_LDIV: begin
        cmd.load_finish = status.div_done;
      end
      l1bp_pkg::ST_PV_INIT: begin
        cmd.pv_init = 1'b1;
      end
      l1bp_pkg::ST_PV_RD: begin
        cmd.pv_read = !status.pv_done;
      end
      l1bp_pkg::ST_PV_CHK: begin
        cmd.pv_check = 1'b1;
      end
      l1bp_pkg::ST_PV_DIV, l1bp_pkg::ST_FI_DIV: begin
        cmd.tau_add = status.div_done;
      end
      l1bp_pkg::ST_FI_INIT: begin
        cmd.fi_init = 1'b1;
      end
      l1bp_pkg::ST_FI_CHK: begin
        cmd.fi_check = 1'b1;
      end
      l1bp_pkg::ST_EMIT_INIT: begin
        cmd.emit_init = 1'b1;
        cmd.clear     = status.sc_zero;
      end
      l1bp_pkg::ST_EMIT_WAIT: begin
        cmd.emit_load = 1'b1;
      end
      l1bp_pkg::ST_EMIT_OUT: begin
        result_valid  = 1'b1;
        cmd.emit_next = result_ready && !status.emit_last;
        cmd.clear     = result_ready && status.emit_last;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule
